>>> sv/hwaf_pkg.sv
// hwaf_pkg: shared types, codes and constants of the hit word assembler framer
// used by every module of the block; depends on nothing
package hwaf_pkg;

   // record closes once the hit word count reaches this value
   localparam int unsigned RECORD_LIMIT = 8190;

   localparam int unsigned COUNT_W = 13;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned HALF_W  = 16;
   localparam int unsigned ID_W    = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   // results one item can cause: two hit words and a close
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned SLOT_W      = 2;

   localparam logic [ID_W-1:0]   ID_RESET   = 8'd102;
   localparam logic [HALF_W-1:0] LANE_MARK  = 16'h0080;
   localparam logic [27:0]       DIRECT_MSK = 28'hFFF_FFFF;
   localparam logic [WORD_W-1:0] CKS_BIAS   = 32'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WORD_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_ID      = 2'd1;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_FLUSH  = 1'b1
   } kind_type;

   typedef enum logic {
      ITEM_HIT   = 1'b0,
      ITEM_CLOSE = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic                  half_word_mode;
      logic [ID_W-1:0]       record_id;
   } cfg_type;

   typedef struct packed {
      item_kind_type         item_type;
      logic [WORD_W-1:0]     word;
      logic [COUNT_W-1:0]    record_count;
   } result_type;

   // all results caused by one item, in emit order
   typedef struct packed {
      logic [SLOT_W-1:0]     count;
      result_type [MAX_RESULTS-1:0] entry;
   } bundle_type;

endpackage

>>> sv/hwaf_csr.sv
// hwaf_csr: configuration registers of the hit word assembler framer
// depends on hwaf_pkg
module hwaf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hwaf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hwaf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output hwaf_pkg::cfg_type                   cfg
);

   hwaf_pkg::cfg_type cfg_ff;
   hwaf_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hwaf_pkg::CSR_HALF_WORD_MODE: cfg_in.half_word_mode = csr_wdata[0];
            hwaf_pkg::CSR_RECORD_ID:      cfg_in.record_id = csr_wdata[hwaf_pkg::ID_W-1:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_word_mode <= 1'b0;
         cfg_ff.record_id      <= hwaf_pkg::ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/hwaf_assemble.sv
// hwaf_assemble: input register, half pairing, word count, checksum and close
// decision; builds the result bundle of one item; depends on hwaf_pkg
module hwaf_assemble (
   input  logic                                clock,
   input  logic                                reset,
   input  hwaf_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [hwaf_pkg::WORD_W-1:0]         req_sample,
   input  logic                                load_ok,
   output logic                                bundle_load,
   output hwaf_pkg::bundle_type                bundle
);

   logic                               in_valid_ff, in_valid_in;
   hwaf_pkg::kind_type                 kind_ff;
   logic [hwaf_pkg::WORD_W-1:0]        sample_ff;
   logic [hwaf_pkg::HALF_W-1:0]        low_first_half_ff, low_first_half_in;
   logic [hwaf_pkg::HALF_W-1:0]        high_first_half_ff, high_first_half_in;
   logic [hwaf_pkg::COUNT_W-1:0]       word_count_ff, word_count_in;
   logic [hwaf_pkg::WORD_W-1:0]        data_xor_ff, data_xor_in;
   logic                               move;
   logic                               accept;

   logic [hwaf_pkg::HALF_W-1:0]        lo, hi;
   logic                               lo_hit, hi_hit, direct_hit, close;
   logic [hwaf_pkg::WORD_W-1:0]        lo_word, hi_word, xor_next;
   logic [hwaf_pkg::COUNT_W-1:0]       count_next;
   logic [hwaf_pkg::SLOT_W-1:0]        slot;

   // the registered item moves on when the output side can take its bundle
   assign move        = in_valid_ff && load_ok;
   assign bundle_load = move;
   assign req_stall   = in_valid_ff && !load_ok;
   assign accept      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)
         in_valid_in = 1'b1;
      else if (move)
         in_valid_in = 1'b0;
   end

   // lane decode and hit words
   assign lo      = sample_ff[hwaf_pkg::HALF_W-1:0];
   assign hi      = sample_ff[hwaf_pkg::WORD_W-1:hwaf_pkg::HALF_W];
   assign lo_word = {lo, low_first_half_ff};
   assign hi_word = {hi, high_first_half_ff | hwaf_pkg::LANE_MARK};

   // per-item work: hits, state update, close and bundle packing
   always_comb begin
      lo_hit             = 1'b0;
      hi_hit             = 1'b0;
      direct_hit         = 1'b0;
      close              = 1'b0;
      low_first_half_in  = low_first_half_ff;
      high_first_half_in = high_first_half_ff;
      xor_next           = data_xor_ff;
      count_next         = word_count_ff;
      bundle             = '0;
      slot               = '0;

      if (kind_ff == hwaf_pkg::KIND_FLUSH) begin
         close = (word_count_ff != '0);
      end else begin
         if (cfg.half_word_mode) begin
            lo_hit = (lo != '0) && lo[0];
            hi_hit = (hi != '0) && hi[0];
            if ((lo != '0) && !lo[0])
               low_first_half_in = lo;
            if ((hi != '0) && !hi[0])
               high_first_half_in = hi;
         end else begin
            direct_hit = ((sample_ff[27:0] & hwaf_pkg::DIRECT_MSK) != 28'd0) && sample_ff[0];
         end
         if (lo_hit)
            xor_next = xor_next ^ lo_word;
         if (hi_hit)
            xor_next = xor_next ^ hi_word;
         if (direct_hit)
            xor_next = xor_next ^ sample_ff;
         count_next = word_count_ff + hwaf_pkg::COUNT_W'(lo_hit)
                      + hwaf_pkg::COUNT_W'(hi_hit) + hwaf_pkg::COUNT_W'(direct_hit);
         close = (count_next >= hwaf_pkg::COUNT_W'(hwaf_pkg::RECORD_LIMIT));
      end

      // hits first, close last
      if (lo_hit) begin
         bundle.entry[slot].item_type = hwaf_pkg::ITEM_HIT;
         bundle.entry[slot].word      = lo_word;
         slot = slot + 2'd1;
      end
      if (hi_hit) begin
         bundle.entry[slot].item_type = hwaf_pkg::ITEM_HIT;
         bundle.entry[slot].word      = hi_word;
         slot = slot + 2'd1;
      end
      if (direct_hit) begin
         bundle.entry[slot].item_type = hwaf_pkg::ITEM_HIT;
         bundle.entry[slot].word      = sample_ff;
         slot = slot + 2'd1;
      end
      if (close) begin
         bundle.entry[slot].item_type    = hwaf_pkg::ITEM_CLOSE;
         bundle.entry[slot].word         = (hwaf_pkg::WORD_W'(count_next) + hwaf_pkg::CKS_BIAS)
                                           ^ hwaf_pkg::WORD_W'(cfg.record_id) ^ xor_next;
         bundle.entry[slot].record_count = count_next;
         slot = slot + 2'd1;
      end
      bundle.count = slot;

      word_count_in = word_count_ff;
      data_xor_in   = data_xor_ff;
      if (move) begin
         word_count_in = close ? '0 : count_next;
         data_xor_in   = close ? '0 : xor_next;
      end
      if (!move) begin
         low_first_half_in  = low_first_half_ff;
         high_first_half_in = high_first_half_ff;
      end
   end

   // control and record state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         low_first_half_ff  <= '0;
         high_first_half_ff <= '0;
         word_count_ff      <= '0;
         data_xor_ff        <= '0;
      end else begin
         in_valid_ff        <= in_valid_in;
         low_first_half_ff  <= low_first_half_in;
         high_first_half_ff <= high_first_half_in;
         word_count_ff      <= word_count_in;
         data_xor_ff        <= data_xor_in;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= hwaf_pkg::kind_type'(req_kind);
         sample_ff <= req_sample;
      end
   end

   // the record never stays open at the limit
   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      word_count_ff < hwaf_pkg::COUNT_W'(hwaf_pkg::RECORD_LIMIT))
      else $error("record left open at the word limit");

   // a stalled input register keeps its item
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load_ok |=> in_valid_ff)
      else $error("input item dropped while blocked");

   // the input only stalls while the input register holds an item
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

endmodule

>>> sv/hwaf_out.sv
// hwaf_out: result register that hands out one bundle entry per cycle while rsp_stall is low
// depends on hwaf_pkg
module hwaf_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                bundle_load,
   input  hwaf_pkg::bundle_type                bundle,
   output logic                                load_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_item_type,
   output logic [hwaf_pkg::WORD_W-1:0]         rsp_word,
   output logic [hwaf_pkg::COUNT_W-1:0]        rsp_record_count,
   output logic                                rsp_last
);

   hwaf_pkg::bundle_type               bundle_ff;
   logic [hwaf_pkg::SLOT_W-1:0]        rem_ff, rem_in;
   logic [hwaf_pkg::SLOT_W-1:0]        idx_ff, idx_in;
   hwaf_pkg::result_type               cur;
   logic                               taken;

   assign rsp_valid = (rem_ff != '0);
   assign taken     = rsp_valid && !rsp_stall;
   // a new bundle may enter once the current one is empty or leaving
   assign load_ok   = (rem_ff == '0) || ((rem_ff == 2'd1) && !rsp_stall);

   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (bundle_load) begin
         rem_in = bundle.count;
         idx_in = '0;
      end else if (taken) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load)
         bundle_ff <= bundle;
   end

   // current entry select
   always_comb begin
      case (idx_ff)
         2'd1:    cur = bundle_ff.entry[1];
         2'd2:    cur = bundle_ff.entry[2];
         default: cur = bundle_ff.entry[0];
      endcase
   end

   assign rsp_item_type    = cur.item_type;
   assign rsp_word         = cur.word;
   assign rsp_record_count = cur.record_count;
   assign rsp_last         = (rem_ff == 2'd1);

   // a bundle is only loaded over an empty or draining register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      bundle_load |-> (rem_ff == '0) || ((rem_ff == 2'd1) && !rsp_stall))
      else $error("bundle overwrote pending results");

   // a close is always the final result of its item
   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cur.item_type == hwaf_pkg::ITEM_CLOSE) |-> rsp_last)
      else $error("close result not last");

   // more results of the same item follow a taken one
   a_bundle_continues: assert property (@(posedge clock) disable iff (reset)
      taken && (rem_ff > 2'd1) |=> rsp_valid && (idx_ff == $past(idx_ff) + 2'd1))
      else $error("bundle entries skipped");

endmodule

>>> sv/hit_word_assembler_framer_top.sv
// hit_word_assembler_framer_top: top level of the hit word assembler framer
// depends on hwaf_pkg, hwaf_csr, hwaf_assemble and hwaf_out
//
// Usage:
//   req_* carries one item: req_kind 0 is a sampled 32-bit port word in
//   req_sample, 1 flushes the open record. An item is taken at a clock edge
//   with req_valid high and req_stall low.
//   rsp_* carries results: hit words (rsp_item_type 0) and record closes
//   (rsp_item_type 1, rsp_word holds the checksum, rsp_record_count the
//   number of data words). rsp_last marks the final result of one item.
//   csr_* writes half_word_mode (index 0) and record_id (index 1); csr_ready
//   is always high. Write only while no item is in flight.
// Path: an item is held in the input register, then its results in the result register.
// Throughput: one item per cycle while each item causes at most one result
//   and rsp_stall is low; an item causing more results occupies the result
//   register until each of them is taken, which is what then sets the rate.
// Reset: clears the stored halves, word count and checksum, sets
//   half_word_mode to 0 and record_id to 102; no results are pending.
// Stall: a stalled result holds; the input register then fills and
//   req_stall rises, holding one more item inside.
module hit_word_assembler_framer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [hwaf_pkg::WORD_W-1:0]         req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_item_type,
   output logic [hwaf_pkg::WORD_W-1:0]         rsp_word,
   output logic [hwaf_pkg::COUNT_W-1:0]        rsp_record_count,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hwaf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hwaf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   hwaf_pkg::cfg_type      cfg;
   hwaf_pkg::bundle_type   bundle;
   logic                   bundle_load;
   logic                   load_ok;

   // configuration registers
   hwaf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // item processing
   hwaf_assemble u_assemble (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_sample  (req_sample),
      .load_ok     (load_ok),
      .bundle_load (bundle_load),
      .bundle      (bundle)
   );

   // result register
   hwaf_out u_out (
      .clock            (clock),
      .reset            (reset),
      .bundle_load      (bundle_load),
      .bundle           (bundle),
      .load_ok          (load_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_type    (rsp_item_type),
      .rsp_word         (rsp_word),
      .rsp_record_count (rsp_record_count),
      .rsp_last         (rsp_last)
   );

endmodule

>>> tb/hit_word_assembler_framer_tb.sv
// tb: self-checking bench for hit_word_assembler_framer_top, with a small
// scoreboard class that predicts hit words and record closes
// depends on hwaf_pkg and hit_word_assembler_framer_top

// one expected or observed result item
typedef struct packed {
   hwaf_pkg::item_kind_type            item_type;
   logic [hwaf_pkg::WORD_W-1:0]        word;
   logic [hwaf_pkg::COUNT_W-1:0]       record_count;
   logic                               last;
} framer_out_type;

// predicts the results of each accepted item and checks the outputs in order
class hit_record_board;
   bit                                 half_mode;
   logic [hwaf_pkg::ID_W-1:0]          rec_id;
   logic [hwaf_pkg::HALF_W-1:0]        low_half;
   logic [hwaf_pkg::HALF_W-1:0]        high_half;
   logic [hwaf_pkg::COUNT_W-1:0]       word_count;
   logic [hwaf_pkg::WORD_W-1:0]        data_xor;
   framer_out_type                     pending_results[$];
   int unsigned                        items_seen;
   int unsigned                        hits_seen;
   int unsigned                        closes_seen;
   int unsigned                        biggest_record;
   int unsigned                        failures;

   function new();
      half_mode = 1'b0;
      rec_id = hwaf_pkg::ID_RESET;
      low_half = '0;
      high_half = '0;
      word_count = '0;
      data_xor = '0;
      items_seen = 0;
      hits_seen = 0;
      closes_seen = 0;
      biggest_record = 0;
      failures = 0;
   endfunction

   // own copy of the register file
   function void apply_write(logic [hwaf_pkg::CSR_INDEX_W-1:0] index,
                             logic [hwaf_pkg::CSR_DATA_W-1:0] data);
      if (index == hwaf_pkg::CSR_HALF_WORD_MODE)
         half_mode = data[0];
      else if (index == hwaf_pkg::CSR_RECORD_ID)
         rec_id = data[hwaf_pkg::ID_W-1:0];
   endfunction

   // append one expected result
   function void queue_result(framer_out_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   function void add_hit_word(logic [hwaf_pkg::WORD_W-1:0] w);
      framer_out_type r;
      r = '{hwaf_pkg::ITEM_HIT, w, '0, 1'b0};
      queue_result(r);
      word_count = word_count + hwaf_pkg::COUNT_W'(1);
      data_xor = data_xor ^ w;
      hits_seen++;
   endfunction

   // checksum covers length plus two, record id and the data words
   function void close_record();
      logic [hwaf_pkg::WORD_W-1:0] cks;
      framer_out_type r;
      cks = ({19'd0, word_count} + hwaf_pkg::CKS_BIAS) ^ {24'd0, rec_id} ^ data_xor;
      r = '{hwaf_pkg::ITEM_CLOSE, cks, word_count, 1'b0};
      queue_result(r);
      if (word_count > biggest_record)
         biggest_record = word_count;
      word_count = '0;
      data_xor = '0;
      closes_seen++;
   endfunction

   function void predict_item(hwaf_pkg::kind_type kind, logic [hwaf_pkg::WORD_W-1:0] sample);
      int unsigned first;
      logic [hwaf_pkg::HALF_W-1:0] lane;
      first = pending_results.size();
      items_seen++;
      if (kind == hwaf_pkg::KIND_FLUSH) begin
         if (word_count != 0)
            close_record();
      end else if (half_mode) begin
         // low lane first, then upper lane, limit tested once at the end
         lane = sample[15:0];
         if (lane != 0) begin
            if (!lane[0])
               low_half = lane;
            else
               add_hit_word({lane, low_half});
         end
         lane = sample[31:16];
         if (lane != 0) begin
            if (!lane[0])
               high_half = lane;
            else
               add_hit_word({lane, high_half | hwaf_pkg::LANE_MARK});
         end
         if (word_count >= hwaf_pkg::RECORD_LIMIT)
            close_record();
      end else begin
         if (sample[27:0] != 0 && sample[0])
            add_hit_word(sample);
         if (word_count >= hwaf_pkg::RECORD_LIMIT)
            close_record();
      end
      if (pending_results.size() > first)
         pending_results[pending_results.size() - 1].last = 1'b1;
   endfunction

   function void check_output(logic item_type, logic [hwaf_pkg::WORD_W-1:0] word,
                              logic [hwaf_pkg::COUNT_W-1:0] count, logic last);
      framer_out_type want;
      if (pending_results.size() == 0) begin
         if (failures < 10)
            $display("unexpected result: type %0d word %h count %0d last %0d",
                     item_type, word, count, last);
         failures++;
         return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (want.item_type !== item_type || want.word !== word ||
          want.record_count !== count || want.last !== last) begin
         if (failures < 10)
            $display("mismatch: expected type %0d word %h count %0d last %0d, %s %0d %s %h %s %0d %s %0d",
                     want.item_type, want.word, want.record_count, want.last,
                     "got type", item_type, "word", word, "count", count, "last", last);
         failures++;
      end
   endfunction
endclass

module tb;

   localparam int unsigned CYCLE_LIMIT  = 2000000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned LONG_HOLD    = 200;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic                                  req_kind = 1'b0;
   logic [hwaf_pkg::WORD_W-1:0]           req_sample = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_item_type;
   logic [hwaf_pkg::WORD_W-1:0]           rsp_word;
   logic [hwaf_pkg::COUNT_W-1:0]          rsp_record_count;
   logic                                  rsp_last;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [hwaf_pkg::CSR_INDEX_W-1:0]      csr_index = '0;
   logic [hwaf_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   hit_record_board          board;
   int unsigned              cycle_count = 0;
   int unsigned              burst_left = 0;
   bit                       gaps_on = 1'b1;
   int unsigned              holds_asked = 0;

   hit_word_assembler_framer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_type    (rsp_item_type),
      .rsp_word         (rsp_word),
      .rsp_record_count (rsp_record_count),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("hit_word_assembler_framer_top test failed");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_output(rsp_item_type, rsp_word, rsp_record_count, rsp_last);
   end

   // receiver stall pattern, plus long hold-offs on request
   initial begin : receiver
      stall_style_type style;
      int unsigned style_left;
      int unsigned hold_left;
      int unsigned tick;
      int unsigned holds_served;
      style = STALL_NONE;
      style_left = 0;
      hold_left = 0;
      tick = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left == 0 && holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (style_left == 0) begin
               style = stall_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(20, 150);
            end
            style_left--;
            case (style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_stall <= (tick % 3 == 0);
               default:        rsp_stall <= ($urandom_range(0, 2) != 0);
            endcase
         end
      end
   end

   // offer one item, with random gaps between bursts
   task automatic send_item(hwaf_pkg::kind_type kind, logic [hwaf_pkg::WORD_W-1:0] sample);
      if (burst_left == 0) begin
         if (gaps_on && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.predict_item(kind, sample);
   endtask

   // stop offering and let every expected result come out
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [hwaf_pkg::CSR_INDEX_W-1:0] index,
                            logic [hwaf_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.apply_write(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(bit half, logic [hwaf_pkg::ID_W-1:0] id);
      settle();
      write_reg(hwaf_pkg::CSR_HALF_WORD_MODE, {7'd0, half});
      write_reg(hwaf_pkg::CSR_RECORD_ID, id);
   endtask

   // lane mix: some zero, some first halves, some joining halves
   function automatic logic [hwaf_pkg::HALF_W-1:0] make_lane();
      logic [hwaf_pkg::HALF_W-1:0] v;
      int unsigned pick;
      v = hwaf_pkg::HALF_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15)
         v = '0;
      else
         v[0] = (pick >= 55);
      return v;
   endfunction

   function automatic logic [hwaf_pkg::WORD_W-1:0] make_sample(bit half);
      int unsigned pick;
      if (half)
         return {make_lane(), make_lane()};
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return $urandom | 32'h1;
      else if (pick < 65)
         return $urandom & 32'hF000_0000;
      return $urandom;
   endfunction

   task automatic random_run(int unsigned count);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            send_item(hwaf_pkg::KIND_FLUSH, $urandom);
         else
            send_item(hwaf_pkg::KIND_SAMPLE, make_sample(board.half_mode));
      end
   endtask

   initial begin : stimulus
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // direct mode at reset settings
      send_item(hwaf_pkg::KIND_FLUSH, 32'hFFFF_FFFF);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0000_0001);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hF000_0001);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hF000_0000);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hFFFF_FFFF);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hFFFF_FFFE);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0000_0000);
      send_item(hwaf_pkg::KIND_FLUSH, 32'h0000_0000);

      // half-word mode: joins before any store, stores, reuse, flush keeps halves
      set_mode(1'b1, 8'd0);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0000_0001);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0001_0000);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hABCE_1234);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hFFFF_8001);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0003_0005);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hFFFE_0000);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0000_FFFE);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h0000_0000);
      send_item(hwaf_pkg::KIND_FLUSH, 32'h0000_0000);
      send_item(hwaf_pkg::KIND_FLUSH, 32'h1234_5678);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'hFFFF_FFFF);
      send_item(hwaf_pkg::KIND_FLUSH, 32'hFFFF_FFFF);

      // top record id in direct mode
      set_mode(1'b0, 8'd255);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h8000_0001);
      send_item(hwaf_pkg::KIND_SAMPLE, 32'h7FFF_FFFF);
      send_item(hwaf_pkg::KIND_FLUSH, 32'h0000_0000);

      // receiver holds off while the sender keeps pushing
      set_mode(1'b1, 8'd255);
      gaps_on = 1'b0;
      holds_asked++;
      repeat (40) send_item(hwaf_pkg::KIND_SAMPLE, make_sample(1'b1));
      gaps_on = 1'b1;

      // random phases over several settings
      set_mode(1'b1, 8'($urandom));
      random_run(40);
      set_mode(1'b0, 8'($urandom));
      random_run(40);
      set_mode(1'b1, 8'd0);
      random_run(35);
      set_mode(1'b0, 8'd102);
      random_run(35);
      send_item(hwaf_pkg::KIND_FLUSH, $urandom);

      settle();
      if (board.pending_results.size() != 0) begin
         $display("%0d expected results never arrived", board.pending_results.size());
         board.failures += board.pending_results.size();
      end
      $display("covered %0d items, %0d hit words, %0d record closes, largest record %0d words",
               board.items_seen, board.hits_seen, board.closes_seen, board.biggest_record);
      $display("both modes, record ids 0 to 255, long receiver hold-off, empty and open flushes");
      if (board.failures == 0)
         $display("hit_word_assembler_framer_top test passed");
      else
         $display("hit_word_assembler_framer_top test failed");
      $finish;
   end

endmodule

>>> files.f
sv/hwaf_pkg.sv
sv/hwaf_csr.sv
sv/hwaf_assemble.sv
sv/hwaf_out.sv
sv/hit_word_assembler_framer_top.sv
tb/hit_word_assembler_framer_tb.sv
